[rtl/core/dsd_pkg.sv]
// Shared types and constants for the dice-sum distribution core.
// Used by dsd_ctrl, dsd_datapath and dice_sum_distribution_core; no dependencies.
`default_nettype none

package dsd_pkg;

    localparam int DEF_MAX_TOTALS = 1024;
    localparam int DEF_MAX_FACES  = 64;

    localparam logic [1:0] CMD_DIE   = 2'd0;
    localparam logic [1:0] CMD_BONUS = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic decode;
        logic exec;
        logic start_pre;
        logic start_dif;
        logic start_qry;
        logic commit;
    } dsd_ctl_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       die_ok;
        logic       q_all;
        logic       q_none;
        logic       pass_done;
    } dsd_sts_t;

endpackage

`default_nettype wire

[rtl/core/dsd_ctrl.sv]
// Sequencing state machine for the dice-sum distribution core.
// Depends on dsd_pkg for the command codes and the control/status structs.
`default_nettype none

module dsd_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic           out_free,
    output logic                out_load,
    input  wire dsd_pkg::dsd_sts_t sts,
    output dsd_pkg::dsd_ctl_t   ctl
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_DECODE = 8'b0000_0010,
        ST_EXEC   = 8'b0000_0100,
        ST_PREFIX = 8'b0000_1000,
        ST_DIFF   = 8'b0001_0000,
        ST_QUERY  = 8'b0010_0000,
        ST_FINISH = 8'b0100_0000,
        ST_OUTPUT = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next    = state_reg;
        ctl           = '0;
        in_ready      = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                ctl.decode = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                ctl.exec   = 1'b1;
                state_next = ST_FINISH;
                if (sts.cmd == dsd_pkg::CMD_DIE && sts.die_ok)
                begin
                    ctl.start_pre = 1'b1;
                    state_next    = ST_PREFIX;
                end
                else if (sts.cmd == dsd_pkg::CMD_QUERY && !sts.q_all && !sts.q_none)
                begin
                    ctl.start_qry = 1'b1;
                    state_next    = ST_QUERY;
                end
            end
            ST_PREFIX:
            begin
                if (sts.pass_done)
                begin
                    ctl.start_dif = 1'b1;
                    state_next    = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                if (sts.pass_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_QUERY:
            begin
                if (sts.pass_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                ctl.commit = 1'b1;
                state_next = ST_OUTPUT;
            end
            ST_OUTPUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/dsd_datapath.sv]
// Datapath of the dice-sum distribution core: ways table memory, pass engine,
// overflow checks and query bounds. Depends on dsd_pkg.
`default_nettype none

module dsd_datapath
#(
    parameter int MAX_TOTALS = dsd_pkg::DEF_MAX_TOTALS,
    parameter int MAX_FACES  = dsd_pkg::DEF_MAX_FACES
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [1:0]          cmd,
    input  wire logic [6:0]          faces,
    input  wire logic signed [15:0]  bonus,
    input  wire logic signed [31:0]  threshold,
    input  wire dsd_pkg::dsd_ctl_t   ctl,
    output dsd_pkg::dsd_sts_t        sts,
    output logic [63:0]              ways_at_or_above,
    output logic [63:0]              total_ways,
    output logic signed [31:0]       min_total,
    output logic signed [31:0]       max_total,
    output logic                     status
);

    localparam int IDX_W = $clog2(MAX_TOTALS);
    localparam int CNT_W = $clog2(MAX_TOTALS + 1);
    localparam int NW    = CNT_W + 8;

    typedef enum logic [2:0] {
        PM_PRE = 3'b001,
        PM_DIF = 3'b010,
        PM_QRY = 3'b100
    } pass_t;

    // latched item
    logic [1:0]         cmd_reg;
    logic [6:0]         faces_reg;
    logic signed [15:0] bonus_reg;
    logic signed [31:0] thr_reg;

    // architectural state
    logic [63:0]        count_reg;
    logic [31:0]        low_reg;
    logic [CNT_W-1:0]   used_reg;

    // decode results
    logic [70:0]        prod_reg;
    logic [CNT_W-1:0]   newn_reg;
    logic               face_bad_reg;
    logic               tbl_bad_reg;
    logic               q_all_reg;
    logic               q_none_reg;
    logic [IDX_W-1:0]   q_start_reg;

    // result
    logic [63:0]        ways_reg;
    logic               status_reg;

    // pass engine
    pass_t              mode_reg;
    logic               iss_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   end_reg;
    logic               p_valid_reg;
    logic               p_last_reg;
    logic               p_sub_reg;
    logic [IDX_W-1:0]   p_addr_reg;
    logic [63:0]        acc_reg;
    logic [63:0]        rd0_reg;
    logic [63:0]        rd1_reg;

    logic [63:0]        mem_q [MAX_TOTALS];

    logic [NW-1:0]      faces_w;
    logic [NW-1:0]      newn_calc;
    logic signed [33:0] lo34;
    logic signed [33:0] t34;
    logic signed [33:0] hi34;
    logic signed [33:0] diff34;
    logic [CNT_W-1:0]   newn_m1;
    logic [CNT_W-1:0]   used_m1;
    logic [IDX_W-1:0]   ra1;
    logic [63:0]        val;
    logic [63:0]        acc_next;
    logic               we;
    logic [63:0]        wd;
    logic               die_ok;
    logic               pass_done;

    assign faces_w   = NW'(faces_reg);
    assign newn_calc = NW'(used_reg) + faces_w - NW'(1);
    assign lo34      = {{2{low_reg[31]}}, low_reg};
    assign t34       = {{2{thr_reg[31]}}, thr_reg};
    assign hi34      = lo34 + $signed({{(34 - CNT_W){1'b0}}, used_reg}) - 34'sd1;
    assign diff34    = t34 - lo34;
    assign newn_m1   = newn_reg - CNT_W'(1);
    assign used_m1   = used_reg - CNT_W'(1);
    assign ra1       = idx_reg - IDX_W'(faces_reg) & {IDX_W{1'b1}};

    assign die_ok    = !face_bad_reg && !tbl_bad_reg && (prod_reg[70:64] == 7'd0);
    assign pass_done = p_valid_reg && p_last_reg;

    // Entries at or above the fill count read as zero; with one entry in use it is 1.
    always_comb
    begin
        if (NW'(p_addr_reg) >= NW'(used_reg))
        begin
            val = 64'd0;
        end
        else if (used_reg == CNT_W'(1))
        begin
            val = 64'd1;
        end
        else
        begin
            val = rd0_reg;
        end
    end

    assign acc_next = acc_reg + val;

    always_comb
    begin
        we = 1'b0;
        wd = acc_next;
        if (p_valid_reg)
        begin
            case (mode_reg)
                PM_PRE:
                begin
                    we = 1'b1;
                    wd = acc_next;
                end
                PM_DIF:
                begin
                    we = 1'b1;
                    wd = rd0_reg - (p_sub_reg ? rd1_reg : 64'd0);
                end
                default:
                begin
                    we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_q[p_addr_reg] <= wd;
        end
        rd0_reg <= mem_q[idx_reg];
        rd1_reg <= mem_q[ra1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= 64'd1;
            low_reg     <= 32'd0;
            used_reg    <= CNT_W'(1);
            iss_reg     <= 1'b0;
            p_valid_reg <= 1'b0;
            mode_reg    <= PM_PRE;
            idx_reg     <= '0;
            end_reg     <= '0;
        end
        else
        begin
            p_valid_reg <= iss_reg;
            if (iss_reg)
            begin
                if (idx_reg == end_reg)
                begin
                    iss_reg <= 1'b0;
                end
                idx_reg <= (mode_reg == PM_DIF) ? idx_reg - IDX_W'(1) : idx_reg + IDX_W'(1);
            end
            if (ctl.start_pre)
            begin
                iss_reg  <= 1'b1;
                mode_reg <= PM_PRE;
                idx_reg  <= '0;
                end_reg  <= newn_m1[IDX_W-1:0];
            end
            if (ctl.start_dif)
            begin
                iss_reg  <= 1'b1;
                mode_reg <= PM_DIF;
                idx_reg  <= newn_m1[IDX_W-1:0];
                end_reg  <= '0;
            end
            if (ctl.start_qry)
            begin
                iss_reg  <= 1'b1;
                mode_reg <= PM_QRY;
                idx_reg  <= q_start_reg;
                end_reg  <= used_m1[IDX_W-1:0];
            end
            if (ctl.commit)
            begin
                if (cmd_reg == dsd_pkg::CMD_DIE && die_ok)
                begin
                    count_reg <= prod_reg[63:0];
                    used_reg  <= newn_reg;
                    low_reg   <= low_reg + 32'd1;
                end
                else if (cmd_reg == dsd_pkg::CMD_BONUS)
                begin
                    low_reg <= low_reg + 32'($signed(bonus_reg));
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        p_addr_reg <= idx_reg;
        p_last_reg <= (idx_reg == end_reg);
        p_sub_reg  <= (NW'(idx_reg) >= faces_w);
        if (ctl.start_pre || ctl.start_dif || ctl.start_qry)
        begin
            acc_reg <= 64'd0;
        end
        else if (p_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        if (ctl.load)
        begin
            cmd_reg    <= cmd;
            faces_reg  <= faces;
            bonus_reg  <= bonus;
            thr_reg    <= threshold;
            ways_reg   <= 64'd0;
            status_reg <= 1'b0;
        end
        if (ctl.decode)
        begin
            prod_reg     <= 71'(count_reg) * 71'(faces_reg);
            newn_reg     <= newn_calc[CNT_W-1:0];
            face_bad_reg <= (faces_reg == 7'd0) || (faces_w > NW'(MAX_FACES));
            tbl_bad_reg  <= newn_calc > NW'(MAX_TOTALS);
            q_all_reg    <= t34 <= lo34;
            q_none_reg   <= t34 > hi34;
            q_start_reg  <= diff34[IDX_W-1:0];
        end
        if (ctl.exec)
        begin
            if (cmd_reg == dsd_pkg::CMD_DIE && !die_ok)
            begin
                status_reg <= 1'b1;
            end
            if (cmd_reg == dsd_pkg::CMD_QUERY && q_all_reg)
            begin
                ways_reg <= count_reg;
            end
        end
        if (pass_done && mode_reg == PM_QRY)
        begin
            ways_reg <= acc_next;
        end
    end

    assign sts.cmd       = cmd_reg;
    assign sts.die_ok    = die_ok;
    assign sts.q_all     = q_all_reg;
    assign sts.q_none    = q_none_reg;
    assign sts.pass_done = pass_done;

    assign ways_at_or_above = ways_reg;
    assign total_ways       = count_reg;
    assign min_total        = $signed(low_reg);
    assign max_total        = $signed(low_reg + 32'(used_reg) - 32'd1);
    assign status           = status_reg;

endmodule

`default_nettype wire

[rtl/core/dice_sum_distribution_core.sv]
// Dice-sum distribution core: a die adds a prefix pass and a difference pass over the table,
// each covering the N totals after the die.
// A query walks entries from the threshold to the top; bonus and spare commands,
// out-of-range queries and rejected dice skip the passes. One item at a time.
// Reset (rst_n, asynchronous, active low) restores one total of zero with one way; the table
// needs no clearing pass since entries above the fill count read as zero.
`default_nettype none

module dice_sum_distribution_core
#(
    parameter int MAX_TOTALS = dsd_pkg::DEF_MAX_TOTALS,
    parameter int MAX_FACES  = dsd_pkg::DEF_MAX_FACES
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [55:0]  s_tdata,   // faces[6:0], bonus[22:7], threshold[54:23], zero pad
    input  wire logic [1:0]   s_tuser,   // cmd[1:0]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [191:0]      m_tdata,   // ways_at_or_above, total_ways, min_total, max_total
    output logic [0:0]        m_tuser    // status[0]
);

    dsd_pkg::dsd_ctl_t ctl;
    dsd_pkg::dsd_sts_t sts;

    logic               out_load;
    logic               out_free;
    logic [63:0]        ways_at_or_above;
    logic [63:0]        total_ways;
    logic signed [31:0] min_total;
    logic signed [31:0] max_total;
    logic               status;

    logic               m_tvalid_reg;
    logic [191:0]       m_tdata_reg;
    logic               m_tuser_reg;

    // The output register frees when empty or when its transfer completes this cycle.
    assign out_free = !m_tvalid_reg || m_tready;

    dsd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .out_load (out_load),
        .sts      (sts),
        .ctl      (ctl)
    );

    dsd_datapath
    #(
        .MAX_TOTALS (MAX_TOTALS),
        .MAX_FACES  (MAX_FACES)
    )
    u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (s_tuser),
        .faces            (s_tdata[6:0]),
        .bonus            ($signed(s_tdata[22:7])),
        .threshold        ($signed(s_tdata[54:23])),
        .ctl              (ctl),
        .sts              (sts),
        .ways_at_or_above (ways_at_or_above),
        .total_ways       (total_ways),
        .min_total        (min_total),
        .max_total        (max_total),
        .status           (status)
    );

    // Hold the result until taken; a new item may be accepted meanwhile.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= {max_total, min_total, total_ways, ways_at_or_above};
            m_tuser_reg <= status;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for dice_sum_distribution_core: directed and random command
// streams, results checked against an in-bench distribution tracker.
// Depends on dsd_pkg and the core RTL only.
`default_nettype none

module testbench;

    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam logic       ST_OK     = 1'b0;
    localparam logic       ST_REJECT = 1'b1;
    localparam int         DEPTH     = dsd_pkg::DEF_MAX_TOTALS;
    localparam int         FACE_MAX  = dsd_pkg::DEF_MAX_FACES;

    typedef struct {
        logic [63:0] ways;
        logic [63:0] total;
        logic [31:0] mn;
        logic [31:0] mx;
        logic        status;
    } roll_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [55:0]  s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;
    logic [0:0]   m_tuser;

    dice_sum_distribution_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Tracked distribution: ways per total, from the lowest total upward
    logic [63:0]  dist_ways [DEPTH];
    logic [63:0]  dist_count;
    logic [31:0]  dist_low;
    int unsigned  dist_used;

    roll_result_t pending_rolls[$];
    int           failures;
    int           n_items;
    int           n_results;
    int           n_rejects;
    int           tx_idle_pct;
    int           rx_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #80000000;
        $display("TEST FAILED");
        $finish;
    end

    // Apply one command to the tracked distribution and return the result it yields
    function automatic roll_result_t track_command(logic [1:0] cmd, logic [6:0] faces,
                                                    logic [15:0] bonus, logic [31:0] thr);
        roll_result_t  r;
        logic [127:0]  prod;
        int unsigned   newn;
        logic [63:0]   acc;
        longint        t;
        longint        lo;
        longint        hi;
        r.ways   = '0;
        r.status = ST_OK;
        case (cmd)
            dsd_pkg::CMD_DIE:
            begin
                prod = {64'd0, dist_count} * {121'd0, faces};
                newn = dist_used + faces - 1;
                if (faces == 0 || faces > FACE_MAX || newn > DEPTH || prod[127:64] != 0)
                    r.status = ST_REJECT;
                else
                begin
                    // top down, so each entry reads only older ones at or below it
                    for (int k = int'(newn) - 1; k >= 0; k--)
                    begin
                        acc = '0;
                        for (int j = 0; j < faces && j <= k; j++)
                            if (k - j < dist_used)
                                acc += dist_ways[k - j];
                        dist_ways[k] = acc;
                    end
                    dist_used  = newn;
                    dist_count = prod[63:0];
                    dist_low   = dist_low + 32'd1;
                end
            end
            dsd_pkg::CMD_BONUS:
                dist_low = dist_low + {{16{bonus[15]}}, bonus};
            dsd_pkg::CMD_QUERY:
            begin
                t  = longint'(signed'(thr));
                lo = longint'(signed'(dist_low));
                hi = lo + longint'(dist_used) - 1;
                if (t <= lo)
                    r.ways = dist_count;
                else if (t <= hi)
                    for (longint i = t - lo; i < dist_used; i++)
                        r.ways += dist_ways[i];
            end
            default: ;
        endcase
        r.total = dist_count;
        r.mn    = dist_low;
        r.mx    = dist_low + dist_used - 1;
        return r;
    endfunction

    // Drive one command and hold it until the transfer; valid is left high unless a random idle gap follows
    task automatic send_command(logic [1:0] cmd, logic [6:0] faces, logic [15:0] bonus,
                                logic [31:0] thr);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, thr, bonus, faces};
        do
            @(posedge clk);
        while (!s_tready);
        pending_rolls.push_back(track_command(cmd, faces, bonus, thr));
        n_items++;
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every outstanding result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_rolls.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic send_query(logic [31:0] thr);
        send_command(dsd_pkg::CMD_QUERY, 7'($urandom), 16'($urandom), thr);
    endtask

    task automatic send_die(logic [6:0] faces);
        send_command(dsd_pkg::CMD_DIE, faces, 16'($urandom), $urandom);
    endtask

    task automatic send_bonus(logic [15:0] bonus);
        send_command(dsd_pkg::CMD_BONUS, 7'($urandom), bonus, $urandom);
    endtask

    // Queries around the current bounds: at, below and above min, at and above max
    task automatic probe_bounds();
        send_query(dist_low);
        send_query(dist_low - 32'd1);
        send_query(dist_low + 32'd1);
        send_query(dist_low + dist_used - 1);
        send_query(dist_low + dist_used);
    endtask

    task automatic test_directed();
        send_query(32'h8000_0000);
        send_query(32'h7FFF_FFFF);
        send_die(7'd1);                 // one face: both bounds move up by one
        send_die(7'd0);                 // no faces: rejected
        send_die(7'd65);                // just past the face limit
        send_die(7'd127);
        send_command(CMD_SPARE, 7'h7F, 16'hFFFF, 32'hFFFF_FFFF);
        send_die(7'd6);
        send_die(7'd2);
        send_die(7'd64);
        probe_bounds();
        send_bonus(16'h8000);
        send_bonus(16'h7FFF);
        send_bonus(16'hFFFD);
        probe_bounds();
        drain_results();
    endtask

    task automatic test_random(int count);
        int   sel;
        logic [31:0] thr;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(99);
            if (sel < 30)
                send_die($urandom_range(9) == 0 ? 7'($urandom) : 7'($urandom_range(6, 1)));
            else if (sel < 45)
                send_bonus($urandom_range(3) == 0 ? 16'($urandom)
                                                  : 16'($urandom_range(40)) - 16'd20);
            else if (sel < 95)
            begin
                thr = ($urandom_range(4) == 0) ? $urandom
                    : dist_low + $urandom_range(dist_used + 3) - 2;
                send_query(thr);
            end
            else
                send_command(CMD_SPARE, 7'($urandom), 16'($urandom), $urandom);
            // occasionally hold off until the core has emptied
            if ($urandom_range(39) == 0)
                drain_results();
        end
        drain_results();
    endtask

    // Stack 64-faced dice until the outcome count would pass 64 bits
    task automatic test_count_overflow();
        for (int i = 0; i < 12; i++)
            send_die(7'd64);
        send_die(7'd2);
        probe_bounds();
        drain_results();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Compare every result transfer with the oldest outstanding expectation
    always @(posedge clk)
    begin
        roll_result_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            if (pending_rolls.size() == 0)
            begin
                $error("result with nothing outstanding");
                failures++;
            end
            else
            begin
                e = pending_rolls.pop_front();
                if (e.status == ST_REJECT)
                    n_rejects++;
                if (m_tdata[63:0] !== e.ways)
                begin
                    $error("ways_at_or_above: expected %0d, got %0d", e.ways, m_tdata[63:0]);
                    failures++;
                end
                if (m_tdata[127:64] !== e.total)
                begin
                    $error("total_ways: expected %0d, got %0d", e.total, m_tdata[127:64]);
                    failures++;
                end
                if (m_tdata[159:128] !== e.mn)
                begin
                    $error("min_total: expected %0d, got %0d",
                           signed'(e.mn), signed'(m_tdata[159:128]));
                    failures++;
                end
                if (m_tdata[191:160] !== e.mx)
                begin
                    $error("max_total: expected %0d, got %0d",
                           signed'(e.mx), signed'(m_tdata[191:160]));
                    failures++;
                end
                if (m_tuser[0] !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, m_tuser[0]);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
            dist_ways[i] = '0;
        dist_ways[0] = 64'd1;
        dist_count   = 64'd1;
        dist_low     = '0;
        dist_used    = 1;
        failures     = 0;
        n_items      = 0;
        n_results    = 0;
        n_rejects    = 0;
        tx_idle_pct  = 8;
        rx_idle_pct  = 82;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = dsd_pkg::CMD_DIE;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(90);
        tx_idle_pct = 82;
        rx_idle_pct = 8;
        test_random(90);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random(90);
        test_count_overflow();

        $display("Sent %0d commands, checked %0d results (%0d rejected dice);",
                 n_items, n_results, n_rejects);
        $display("final spread %0d totals over %0d outcomes.", dist_used, dist_count);
        if (failures == 0 && pending_rolls.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
